>>> rtl/gms_pkg.sv
// Shared types, constants and small functions for the packed genotype matrix store.
// Used by gms_loader, gms_query and the top level. No dependencies.
`timescale 1ns / 1ps

package gms_pkg;

  localparam int MEM_ADDR_BITS_DEF = 16;

  localparam logic [7:0] MAGIC_A = 8'h6C;
  localparam logic [7:0] MAGIC_B = 8'h1B;
  localparam logic [7:0] MODE_VARIANT_MAJOR = 8'h01;

  // Configuration register indexes.
  localparam logic [1:0] REG_NUM_INDIVIDUALS = 2'd0;
  localparam logic [1:0] REG_NUM_LOCI        = 2'd1;

  // Input operation codes.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] GENO_MASK = 2'b11;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_MAGIC  = 3'd1,
    ST_TOO_LONG   = 3'd2,
    ST_TOO_SHORT  = 3'd3,
    ST_CAPACITY   = 3'd4,
    ST_NOT_LOADED = 3'd5,
    ST_INDEX      = 3'd6
  } status_t;

  // Position within the stream header; HDR_DATA covers the matrix bytes.
  typedef enum logic [1:0] {
    HDR_MAGIC_A = 2'd0,
    HDR_MAGIC_B = 2'd1,
    HDR_MODE    = 2'd2,
    HDR_DATA    = 2'd3
  } hdr_t;

  // Matrix layout handed from the loader to the query side.
  typedef struct packed {
    logic       loaded;
    logic       variant_major;
    logic [4:0] stride_log2;
  } geom_t;

  // Two-bit genotype code to minor allele count; 3 means missing.
  function automatic logic [1:0] code_to_count(input logic [1:0] code);
    logic [1:0] cnt;
    case (code)
      2'b00:   cnt = 2'd2;
      2'b01:   cnt = 2'd3;
      2'b10:   cnt = 2'd1;
      default: cnt = 2'd0;
    endcase
    return cnt;
  endfunction

  // Smallest s with (1 << s) >= len; independent compares over 15 bits.
  function automatic logic [4:0] stride_for_len(input logic [14:0] len);
    logic [4:0] s;
    s = 5'd0;
    for (int i = 0; i < 15; i++) begin
      if ((17'd1 << i) < {2'b00, len}) begin
        s = 5'(i + 1);
      end
    end
    return s;
  endfunction

endpackage

>>> rtl/gms_mem.sv
// Byte-wide genotype memory: one write port, one registered read port.
// Depends on nothing beyond its parameter.
`timescale 1ns / 1ps

module gms_mem #(
  parameter int ADDR_BITS = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [7:0]           wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [7:0]           rdata
);

  logic [7:0] mem [(1 << ADDR_BITS)];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/gms_loader.sv
// Stream loader: header parsing, geometry, write addressing and load status.
// Depends on gms_pkg.
`timescale 1ns / 1ps

module gms_loader #(
  parameter int MEM_ADDR_BITS = gms_pkg::MEM_ADDR_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     load_acc,
  input  logic                     cfg_wr,
  input  logic [7:0]               stream_byte,
  input  logic                     stream_last,
  input  logic [15:0]              num_individuals,
  input  logic [15:0]              num_loci,
  output logic                     mem_we,
  output logic [MEM_ADDR_BITS-1:0] mem_waddr,
  output logic [7:0]               mem_wdata,
  output gms_pkg::status_t         load_status,
  output gms_pkg::geom_t           geom
);

  gms_pkg::hdr_t    hdr_r, hdr_nxt;
  gms_pkg::status_t err_r, err_nxt, err_fin;
  logic             vm_r, vm_nxt;
  logic [4:0]       stride_r, stride_nxt;
  logic [15:0]      row_r, row_nxt;
  logic [14:0]      byte_r, byte_nxt;
  logic             loaded_r, loaded_nxt;

  logic [15:0] rows, cols;
  logic [16:0] cols_sum;
  logic [14:0] row_len;
  logic [4:0]  stride_new;
  logic        complete_cur, complete_aft, data_write;

  // Geometry follows the mode byte in the same cycle it arrives.
  always_comb begin
    vm_nxt = vm_r;
    if (load_acc && err_r == gms_pkg::ST_OK && hdr_r == gms_pkg::HDR_MODE) begin
      vm_nxt = (stream_byte == gms_pkg::MODE_VARIANT_MAJOR);
    end
    rows       = vm_nxt ? num_loci : num_individuals;
    cols       = vm_nxt ? num_individuals : num_loci;
    cols_sum   = {1'b0, cols} + 17'd3;
    row_len    = cols_sum[16:2];
    stride_new = gms_pkg::stride_for_len(row_len);
    complete_cur = (rows == 16'd0) || (row_len == 15'd0) || (row_r >= rows);
    data_write = load_acc && err_r == gms_pkg::ST_OK && hdr_r == gms_pkg::HDR_DATA
                 && !complete_cur;
  end

  always_comb begin
    hdr_nxt    = hdr_r;
    err_nxt    = err_r;
    stride_nxt = stride_r;
    row_nxt    = row_r;
    byte_nxt   = byte_r;
    loaded_nxt = loaded_r;
    err_fin    = err_r;
    complete_aft = 1'b0;
    if (cfg_wr) begin
      loaded_nxt = 1'b0;
    end
    if (load_acc) begin
      if (hdr_r == gms_pkg::HDR_MAGIC_A && err_r == gms_pkg::ST_OK) begin
        loaded_nxt = 1'b0;
      end
      if (err_r == gms_pkg::ST_OK) begin
        case (hdr_r)
          gms_pkg::HDR_MAGIC_A: begin
            if (stream_byte != gms_pkg::MAGIC_A) err_nxt = gms_pkg::ST_BAD_MAGIC;
            else hdr_nxt = gms_pkg::HDR_MAGIC_B;
          end
          gms_pkg::HDR_MAGIC_B: begin
            if (stream_byte != gms_pkg::MAGIC_B) err_nxt = gms_pkg::ST_BAD_MAGIC;
            else hdr_nxt = gms_pkg::HDR_MODE;
          end
          gms_pkg::HDR_MODE: begin
            stride_nxt = stride_new;
            if ((32'(rows) << stride_new) > (32'd1 << MEM_ADDR_BITS)) begin
              err_nxt = gms_pkg::ST_CAPACITY;
            end
            hdr_nxt  = gms_pkg::HDR_DATA;
            row_nxt  = 16'd0;
            byte_nxt = 15'd0;
          end
          default: begin
            if (complete_cur) begin
              err_nxt = gms_pkg::ST_TOO_LONG;
            end else if (byte_r + 15'd1 >= row_len) begin
              byte_nxt = 15'd0;
              row_nxt  = row_r + 16'd1;
            end else begin
              byte_nxt = byte_r + 15'd1;
            end
          end
        endcase
      end
      err_fin = err_nxt;
      complete_aft = (rows == 16'd0) || (row_len == 15'd0) || (row_nxt >= rows);
      if (stream_last) begin
        if (err_nxt == gms_pkg::ST_OK &&
            (hdr_nxt != gms_pkg::HDR_DATA || !complete_aft)) begin
          err_fin = gms_pkg::ST_TOO_SHORT;
        end
        loaded_nxt = (err_fin == gms_pkg::ST_OK);
        hdr_nxt    = gms_pkg::HDR_MAGIC_A;
        row_nxt    = 16'd0;
        byte_nxt   = 15'd0;
        err_nxt    = gms_pkg::ST_OK;
      end
    end
  end

  always_comb begin
    mem_we      = data_write;
    mem_waddr   = MEM_ADDR_BITS'((32'(row_r) << stride_r) | 32'(byte_r));
    mem_wdata   = stream_byte;
    load_status = err_fin;
    geom        = '{loaded: loaded_r, variant_major: vm_r, stride_log2: stride_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r    <= gms_pkg::HDR_MAGIC_A;
      err_r    <= gms_pkg::ST_OK;
      vm_r     <= 1'b0;
      stride_r <= 5'd0;
      row_r    <= 16'd0;
      byte_r   <= 15'd0;
      loaded_r <= 1'b0;
    end else begin
      hdr_r    <= hdr_nxt;
      err_r    <= err_nxt;
      vm_r     <= vm_nxt;
      stride_r <= stride_nxt;
      row_r    <= row_nxt;
      byte_r   <= byte_nxt;
      loaded_r <= loaded_nxt;
    end
  end

endmodule

>>> rtl/gms_query.sv
// Lookup side: range checks, read addressing, genotype decode and result register.
// Depends on gms_pkg; reads through the registered port of gms_mem.
`timescale 1ns / 1ps

module gms_query #(
  parameter int MEM_ADDR_BITS = gms_pkg::MEM_ADDR_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     item_acc,
  input  logic                     op,
  input  gms_pkg::status_t         load_status,
  input  logic [15:0]              individual_index,
  input  logic [15:0]              locus_index,
  input  logic [15:0]              num_individuals,
  input  logic [15:0]              num_loci,
  input  gms_pkg::geom_t           geom,
  output logic                     mem_re,
  output logic [MEM_ADDR_BITS-1:0] mem_raddr,
  input  logic [7:0]               mem_rdata,
  output logic                     out_valid,
  output logic [1:0]               out_allele_count,
  output logic [2:0]               out_status
);

  gms_pkg::status_t status_nxt, status_r;
  logic             valid_r;
  logic             decode_r;
  logic [1:0]       col_lo_r;
  logic [15:0]      row, col;
  logic [1:0]       code;

  always_comb begin
    row = geom.variant_major ? locus_index : individual_index;
    col = geom.variant_major ? individual_index : locus_index;
    mem_raddr = MEM_ADDR_BITS'((32'(row) << geom.stride_log2) | 32'(col[15:2]));
    if (op == gms_pkg::OP_LOAD) begin
      status_nxt = load_status;
    end else if (!geom.loaded) begin
      status_nxt = gms_pkg::ST_NOT_LOADED;
    end else if (individual_index >= num_individuals || locus_index >= num_loci) begin
      status_nxt = gms_pkg::ST_INDEX;
    end else begin
      status_nxt = gms_pkg::ST_OK;
    end
    mem_re = item_acc && op == gms_pkg::OP_QUERY && status_nxt == gms_pkg::ST_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      decode_r <= 1'b0;
    end else begin
      valid_r  <= item_acc;
      decode_r <= mem_re;
    end
  end

  always_ff @(posedge clk) begin
    if (item_acc) begin
      status_r <= status_nxt;
      col_lo_r <= col[1:0];
    end
  end

  // The read data arrives with the result cycle; only the lane select remains.
  assign code             = gms_pkg::GENO_MASK & 2'(mem_rdata >> {col_lo_r, 1'b0});
  assign out_valid        = valid_r;
  assign out_allele_count = decode_r ? gms_pkg::code_to_count(code) : 2'd0;
  assign out_status       = status_r;

endmodule

>>> rtl/packed_genotype_matrix_store.sv
// Top level of the packed genotype matrix store: configuration registers and wiring.
// Depends on gms_pkg, gms_mem, gms_loader and gms_query.
//
//  channel | ports                                   | transfer when
//  --------+-----------------------------------------+-------------------------
//  input   | start, busy, in_op, in_stream_byte, ... | start && !busy
//  result  | out_valid, out_allele_count, out_status | out_valid (one cycle)
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | cfg_valid && cfg_ready
//
// One item per cycle: a load byte is written to memory at its own transfer edge, and
// every result appears on the cycle after its transfer, set by the registered read of
// the genotype memory. Loads write at the edge before any following query reads.
// Reset is synchronous; the memory is not cleared and holds garbage until loaded.
// The receiver cannot stall, so busy stays low.
`timescale 1ns / 1ps

module packed_genotype_matrix_store #(
  parameter int MEM_ADDR_BITS = gms_pkg::MEM_ADDR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_op,
  input  logic [7:0]  in_stream_byte,
  input  logic        in_stream_last,
  input  logic [15:0] in_individual_index,
  input  logic [15:0] in_locus_index,
  output logic        out_valid,
  output logic [1:0]  out_allele_count,
  output logic [2:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] num_individuals_r, num_individuals_nxt;
  logic [15:0] num_loci_r, num_loci_nxt;
  logic        item_acc, load_acc, cfg_wr;

  logic                     mem_we, mem_re;
  logic [MEM_ADDR_BITS-1:0] mem_waddr, mem_raddr;
  logic [7:0]               mem_wdata, mem_rdata;
  gms_pkg::status_t         load_status;
  gms_pkg::geom_t           geom;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign item_acc  = start && !busy;
  assign load_acc  = item_acc && in_op == gms_pkg::OP_LOAD;

  always_comb begin
    num_individuals_nxt = num_individuals_r;
    num_loci_nxt        = num_loci_r;
    cfg_wr              = 1'b0;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gms_pkg::REG_NUM_INDIVIDUALS: begin
          num_individuals_nxt = cfg_data;
          cfg_wr = 1'b1;
        end
        gms_pkg::REG_NUM_LOCI: begin
          num_loci_nxt = cfg_data;
          cfg_wr = 1'b1;
        end
        default: begin
          cfg_wr = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_individuals_r <= 16'd1;
      num_loci_r        <= 16'd1;
    end else begin
      num_individuals_r <= num_individuals_nxt;
      num_loci_r        <= num_loci_nxt;
    end
  end

  gms_loader #(.MEM_ADDR_BITS(MEM_ADDR_BITS)) u_loader (
    .clk             (clk),
    .rst_n           (rst_n),
    .load_acc        (load_acc),
    .cfg_wr          (cfg_wr),
    .stream_byte     (in_stream_byte),
    .stream_last     (in_stream_last),
    .num_individuals (num_individuals_r),
    .num_loci        (num_loci_r),
    .mem_we          (mem_we),
    .mem_waddr       (mem_waddr),
    .mem_wdata       (mem_wdata),
    .load_status     (load_status),
    .geom            (geom)
  );

  gms_mem #(.ADDR_BITS(MEM_ADDR_BITS)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  gms_query #(.MEM_ADDR_BITS(MEM_ADDR_BITS)) u_query (
    .clk              (clk),
    .rst_n            (rst_n),
    .item_acc         (item_acc),
    .op               (in_op),
    .load_status      (load_status),
    .individual_index (in_individual_index),
    .locus_index      (in_locus_index),
    .num_individuals  (num_individuals_r),
    .num_loci         (num_loci_r),
    .geom             (geom),
    .mem_re           (mem_re),
    .mem_raddr        (mem_raddr),
    .mem_rdata        (mem_rdata),
    .out_valid        (out_valid),
    .out_allele_count (out_allele_count),
    .out_status       (out_status)
  );

  // Exactly one result follows every transfer, on the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    item_acc |=> out_valid) else $error("missing result after transfer");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    !item_acc |=> !out_valid) else $error("result without transfer");

  // The memory is only written by a load byte, never by a lookup.
  a_write_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> load_acc) else $error("memory write outside a load transfer");

  // A failed lookup never carries an allele count.
  a_count_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != gms_pkg::ST_OK) |-> out_allele_count == 2'd0)
    else $error("allele count on a failed result");

endmodule
